// ===== hdl/lmrs_pkg.sv =====
`default_nettype none

package lmrs_pkg;

    localparam int LINE_W = 11;
    localparam int DUTY_W = 8;

    typedef enum logic [1:0] {
        KIND_COLUMN = 2'd0,
        KIND_ROW    = 2'd1,
        KIND_LATCH  = 2'd2,
        KIND_RESET  = 2'd3
    } pulse_kind_t;

    typedef struct packed {
        pulse_kind_t        kind;
        logic               data_bit;
        logic               blank;
        logic [DUTY_W-1:0]  duty;
        logic               last;
    } pulse_t;

endpackage

`default_nettype wire

// ===== hdl/led_matrix_row_scan_driver.sv =====
// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+------------------------------------------
// in        | input     | in_valid/in_stall | cmd, line_bits
// out       | output    | out_valid/out_stall | pulse_kind, data_bit, blank, enable_duty, last
// cfg       | input     | cfg_valid/cfg_ready | cfg_data (dim_level)
//
// one pulse item per cycle through a single output register, unless out_stall holds it
// a line gives COLUMN_COUNT+3 pulses on the first row, COLUMN_COUNT+2 otherwise; a reset gives one
// the next item is taken in the cycle the last pulse of the current one is registered
// out_stall with out_valid high holds the output register and pauses the pulse sequencer
// reset clears the row position, dim_level and all valid flags
`default_nettype none

module led_matrix_row_scan_driver #(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 11
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         cmd,
    input  wire logic [lmrs_pkg::LINE_W-1:0]  line_bits,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [1:0]                        pulse_kind,
    output logic                              data_bit,
    output logic                              blank,
    output logic [lmrs_pkg::DUTY_W-1:0]       enable_duty,
    output logic                              last,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lmrs_pkg::DUTY_W-1:0]  cfg_data
);

    logic [lmrs_pkg::DUTY_W-1:0] dim_reg;
    logic                        out_valid_reg, out_valid_next;
    lmrs_pkg::pulse_t            pulse_reg;
    lmrs_pkg::pulse_t            cur_pulse;
    logic                        busy;
    logic                        out_free;
    logic                        advance;
    logic                        start;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = busy && out_free;
    assign in_stall  = busy && !(advance && cur_pulse.last);
    assign start     = in_valid && !in_stall;

    lmrs_seq #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_cmd  (cmd),
        .start_line (line_bits),
        .advance    (advance),
        .dim_level  (dim_reg),
        .busy       (busy),
        .pulse      (cur_pulse)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dim_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                dim_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pulse_reg <= cur_pulse;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pulse_kind  = pulse_reg.kind;
    assign data_bit    = pulse_reg.data_bit;
    assign blank       = pulse_reg.blank;
    assign enable_duty = pulse_reg.duty;
    assign last        = pulse_reg.last;

endmodule

`default_nettype wire

// ===== hdl/lmrs_seq.sv =====
`default_nettype none

module lmrs_seq #(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 11
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         start_cmd,
    input  wire logic [lmrs_pkg::LINE_W-1:0]  start_line,
    input  wire logic                         advance,
    input  wire logic [lmrs_pkg::DUTY_W-1:0]  dim_level,
    output logic                              busy,
    output lmrs_pkg::pulse_t                  pulse
);

    localparam int STEP_W = $clog2(COLUMN_COUNT + 3);
    localparam int ROW_W  = $clog2(ROW_COUNT);
    localparam logic [STEP_W-1:0] STEP_LAST_COL = STEP_W'(COLUMN_COUNT - 1);
    localparam logic [STEP_W-1:0] STEP_ROW_ONE  = STEP_W'(COLUMN_COUNT);
    localparam logic [STEP_W-1:0] STEP_ROW_ZERO = STEP_W'(COLUMN_COUNT + 1);
    localparam logic [STEP_W-1:0] STEP_LATCH    = STEP_W'(COLUMN_COUNT + 2);
    localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROW_COUNT - 1);

    logic                        busy_reg, busy_next;
    logic                        cmd_reg, cmd_next;
    logic [lmrs_pkg::LINE_W-1:0] line_reg, line_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [lmrs_pkg::LINE_W-1:0] shifted;

    assign shifted = line_reg >> step_reg;
    assign busy    = busy_reg;

    always_comb
    begin
        pulse.kind     = lmrs_pkg::KIND_COLUMN;
        pulse.data_bit = ~shifted[0];
        pulse.blank    = 1'b0;
        pulse.duty     = '0;
        pulse.last     = 1'b0;
        if (cmd_reg)
        begin
            pulse.kind     = lmrs_pkg::KIND_RESET;
            pulse.data_bit = 1'b0;
            pulse.blank    = 1'b1;
            pulse.duty     = dim_level;
            pulse.last     = 1'b1;
        end
        else if (step_reg == STEP_ROW_ONE)
        begin
            pulse.kind     = lmrs_pkg::KIND_ROW;
            pulse.data_bit = 1'b1;
            pulse.blank    = 1'b1;
        end
        else if (step_reg == STEP_ROW_ZERO)
        begin
            pulse.kind     = lmrs_pkg::KIND_ROW;
            pulse.data_bit = 1'b0;
            pulse.blank    = 1'b1;
        end
        else if (step_reg == STEP_LATCH)
        begin
            pulse.kind     = lmrs_pkg::KIND_LATCH;
            pulse.data_bit = 1'b0;
            pulse.blank    = 1'b1;
            pulse.duty     = dim_level;
            pulse.last     = 1'b1;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cmd_next  = cmd_reg;
        line_next = line_reg;
        step_next = step_reg;
        row_next  = row_reg;
        if (advance)
        begin
            if (pulse.last)
            begin
                busy_next = 1'b0;
            end
            if (cmd_reg)
            begin
                row_next = '0;
            end
            else if (step_reg == STEP_LATCH)
            begin
                row_next = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
            end
            if (step_reg == STEP_LAST_COL)
            begin
                step_next = (row_reg == '0) ? STEP_ROW_ONE : STEP_ROW_ZERO;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            cmd_next  = start_cmd;
            line_next = start_line;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cmd_reg  <= 1'b0;
            step_reg <= '0;
            row_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cmd_reg  <= cmd_next;
            step_reg <= step_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

endmodule

`default_nettype wire
